/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/spm_pkg.sv */
package spm_pkg;

    localparam int DIM_X_DEF      = 32;
    localparam int DIM_Y_DEF      = 32;
    localparam int DIM_Z_DEF      = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int SIZE_W         = 6;
    localparam int POS_W          = 5;
    localparam int FIELD_W        = 32;
    localparam int CFG_IDX_W      = 2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2,
        CFG_MODE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        STEP_CENTER = 3'd0,
        STEP_XM     = 3'd1,
        STEP_XP     = 3'd2,
        STEP_YM     = 3'd3,
        STEP_YP     = 3'd4,
        STEP_ZM     = 3'd5,
        STEP_ZP     = 3'd6,
        STEP_RHS    = 3'd7
    } step_t;

    typedef struct packed {
        logic  use_term;
        logic  subtract;
        logic  rhs_term;
        step_t step;
    } term_ctl_t;

    typedef struct packed {
        logic load;
        logic bad;
    } out_ctl_t;

endpackage

/* hdl/spm_ram.sv */
module spm_ram #(
    parameter int AW = 15,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/spm_mac.sv */
module spm_mac import spm_pkg::*; #(
    parameter int VW = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  term_ctl_t            issue_ctl,
    input  logic signed [VW-1:0] center_q,
    input  logic signed [VW-1:0] right_q,
    input  logic signed [VW-1:0] up_q,
    input  logic signed [VW-1:0] front_q,
    input  logic signed [VW-1:0] rhs_q,
    input  logic signed [VW-1:0] vec_q,
    output logic signed [FIELD_W-1:0] result,
    output logic                 saturated
);

    localparam int PW = 2 * VW;
    localparam int AW = PW + 4;

    term_ctl_t ctl1_reg, ctl2_reg;
    logic signed [VW-1:0] coef_sel;
    logic signed [PW-1:0] prod_next, prod_reg;
    logic signed [AW-1:0] acc_reg, acc_next, shifted;
    logic                 fits;
    logic signed [VW-1:0] value;

    always_comb begin
        case (ctl1_reg.step)
            STEP_CENTER: coef_sel = center_q;
            STEP_XM, STEP_XP: coef_sel = right_q;
            STEP_YM, STEP_YP: coef_sel = up_q;
            STEP_ZM, STEP_ZP: coef_sel = front_q;
            STEP_RHS: coef_sel = rhs_q;
            default: coef_sel = center_q;
        endcase
        if (ctl1_reg.rhs_term) begin
            prod_next = PW'(rhs_q) <<< FRAC_BITS;
        end else begin
            prod_next = PW'(coef_sel) * PW'(vec_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            ctl1_reg <= issue_ctl;
            ctl2_reg <= ctl1_reg;
        end
        prod_reg <= prod_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (ctl2_reg.use_term) begin
            if (ctl2_reg.subtract) begin
                acc_next = acc_reg - AW'(prod_reg);
            end else begin
                acc_next = acc_reg + AW'(prod_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        shifted = acc_reg >>> FRAC_BITS;
        fits = (shifted[AW-1:VW-1] == '0) || (shifted[AW-1:VW-1] == '1);
        if (fits) begin
            value = shifted[VW-1:0];
        end else if (shifted[AW-1]) begin
            value = {1'b1, {(VW-1){1'b0}}};
        end else begin
            value = {1'b0, {(VW-1){1'b1}}};
        end
        result    = FIELD_W'(value);
        saturated = !fits;
    end

endmodule

/* hdl/spm_seq.sv */
module spm_seq import spm_pkg::*; #(
    parameter int DIM_X_MAX = DIM_X_DEF,
    parameter int DIM_Y_MAX = DIM_Y_DEF,
    parameter int DIM_Z_MAX = DIM_Z_DEF,
    parameter int AW        = 15
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [POS_W-1:0]  s_pos_i,
    input  logic [POS_W-1:0]  s_pos_j,
    input  logic [POS_W-1:0]  s_pos_k,
    input  logic [SIZE_W-1:0] size_x,
    input  logic [SIZE_W-1:0] size_y,
    input  logic [SIZE_W-1:0] size_z,
    input  logic              mode,
    input  logic              out_free,
    output logic              ld_en,
    output logic [AW-1:0]     ld_addr,
    output logic              clear,
    output term_ctl_t         issue_ctl,
    output logic [AW-1:0]     coef_addr,
    output logic [AW-1:0]     vec_addr,
    output out_ctl_t          out_ctl
);

    localparam logic [AW-1:0] OFF_Y = AW'(DIM_X_MAX);
    localparam logic [AW-1:0] OFF_Z = AW'(DIM_X_MAX * DIM_Y_MAX);

    seq_state_t state_reg, state_next;
    step_t      step_reg;
    logic       drain_reg;
    logic       bad_reg;
    logic [5:0] nb_reg;
    logic [AW-1:0] p_reg;

    logic        accept, in_store, bad_in;
    logic [5:0]  nb_in;
    logic [31:0] pi, pj, pk;

    always_comb begin
        pi = 32'(s_pos_i);
        pj = 32'(s_pos_j);
        pk = 32'(s_pos_k);
        accept   = s_valid && s_ready;
        in_store = (pi < 32'(DIM_X_MAX)) && (pj < 32'(DIM_Y_MAX)) && (pk < 32'(DIM_Z_MAX));
        ld_addr  = AW'((AW'(s_pos_k) * AW'(DIM_Y_MAX) + AW'(s_pos_j)) * AW'(DIM_X_MAX)
                       + AW'(s_pos_i));
        ld_en    = accept && (s_operation == OP_LOAD) && in_store;
        bad_in   = !(pi < 32'(size_x) && pj < 32'(size_y) && pk < 32'(size_z) && in_store);
        nb_in[0] = pi != 32'd0;
        nb_in[1] = (pi + 32'd1 < 32'(size_x)) && (pi + 32'd1 < 32'(DIM_X_MAX));
        nb_in[2] = pj != 32'd0;
        nb_in[3] = (pj + 32'd1 < 32'(size_y)) && (pj + 32'd1 < 32'(DIM_Y_MAX));
        nb_in[4] = pk != 32'd0;
        nb_in[5] = (pk + 32'd1 < 32'(size_z)) && (pk + 32'd1 < 32'(DIM_Z_MAX));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_COMPUTE) begin
                    state_next = bad_in ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_RHS) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_CENTER;
            drain_reg <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_operation == OP_COMPUTE) begin
                        step_reg  <= STEP_CENTER;
                        drain_reg <= 1'b0;
                        bad_reg   <= bad_in;
                    end
                end
                ST_RUN: step_reg <= step_t'(3'(step_reg) + 3'd1);
                ST_DRAIN: drain_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_reg  <= ld_addr;
            nb_reg <= nb_in;
        end
    end

    always_comb begin
        s_ready   = state_reg == ST_IDLE;
        clear     = accept && (s_operation == OP_COMPUTE);
        coef_addr = p_reg;
        vec_addr  = p_reg;
        issue_ctl.step     = step_reg;
        issue_ctl.rhs_term = step_reg == STEP_RHS;
        issue_ctl.subtract = mode && (step_reg != STEP_RHS);
        issue_ctl.use_term = 1'b0;
        case (step_reg)
            STEP_CENTER: issue_ctl.use_term = 1'b1;
            STEP_XM: begin
                coef_addr = p_reg - AW'(1);
                vec_addr  = p_reg - AW'(1);
                issue_ctl.use_term = nb_reg[0];
            end
            STEP_XP: begin
                vec_addr = p_reg + AW'(1);
                issue_ctl.use_term = nb_reg[1];
            end
            STEP_YM: begin
                coef_addr = p_reg - OFF_Y;
                vec_addr  = p_reg - OFF_Y;
                issue_ctl.use_term = nb_reg[2];
            end
            STEP_YP: begin
                vec_addr = p_reg + OFF_Y;
                issue_ctl.use_term = nb_reg[3];
            end
            STEP_ZM: begin
                coef_addr = p_reg - OFF_Z;
                vec_addr  = p_reg - OFF_Z;
                issue_ctl.use_term = nb_reg[4];
            end
            STEP_ZP: begin
                vec_addr = p_reg + OFF_Z;
                issue_ctl.use_term = nb_reg[5];
            end
            STEP_RHS: issue_ctl.use_term = mode;
            default: issue_ctl.use_term = 1'b0;
        endcase
        if (state_reg != ST_RUN) begin
            issue_ctl.use_term = 1'b0;
        end
        out_ctl.load = (state_reg == ST_DONE) && out_free;
        out_ctl.bad  = bad_reg;
    end

endmodule

/* hdl/seven_point_stencil_matvec.sv */
// Seven-point stencil matrix-vector block on a 3D grid, Q16.16 fixed point.
// The input channel (s_valid, s_ready) takes one word per item. A load word
// writes the center, right, up and front coefficients, the vector value and
// the right-hand side of one grid point and returns nothing; s_ready stays
// high after it. A compute word returns one result word on the m_ channel:
// the stencil product at that point, or rhs minus it when mode is 1.
// A compute makes eight passes through the shared multiplier path (center,
// six neighbors, right-hand side, shifted rather than multiplied), each
// issuing one read to the coefficient and vector memories, then the memory
// read, product and accumulate stages. A point outside the grid skips the
// passes and gives its result with bad_index set. s_ready is low from a
// compute's acceptance until its result is in the output register.
// The result sits in an output register; a new item is taken while it
// waits, but a finished compute holds until the receiver takes the old one.
// Reset (aresetn low, synchronous) returns the sizes to 32 and mode to 0 and
// drops any pending result; memory is kept, undefined until loaded. Configuration
// is written through cfg_wr_en by the user, only while idle; the block does not check.
`include "assert_macros.svh"

module seven_point_stencil_matvec import spm_pkg::*; #(
    parameter int DIM_X_MAX  = DIM_X_DEF,
    parameter int DIM_Y_MAX  = DIM_Y_DEF,
    parameter int DIM_Z_MAX  = DIM_Z_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [SIZE_W-1:0]         cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic [POS_W-1:0]          s_pos_i,
    input  logic [POS_W-1:0]          s_pos_j,
    input  logic [POS_W-1:0]          s_pos_k,
    input  logic signed [FIELD_W-1:0] s_coef_center,
    input  logic signed [FIELD_W-1:0] s_coef_right,
    input  logic signed [FIELD_W-1:0] s_coef_up,
    input  logic signed [FIELD_W-1:0] s_coef_front,
    input  logic signed [FIELD_W-1:0] s_vec_value,
    input  logic signed [FIELD_W-1:0] s_rhs_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FIELD_W-1:0] m_result_value,
    output logic                      m_saturated,
    output logic                      m_bad_index
);

    localparam int AW = $clog2(DIM_X_MAX * DIM_Y_MAX * DIM_Z_MAX);
    localparam int VW = VALUE_BITS;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic              mode_reg;

    logic                 ld_en, clear, out_free;
    logic [AW-1:0]        ld_addr, coef_addr, vec_addr;
    term_ctl_t            issue_ctl;
    out_ctl_t             out_ctl;
    logic signed [VW-1:0] center_q, right_q, up_q, front_q, rhs_q, vec_q;
    logic signed [FIELD_W-1:0] mac_result;
    logic                 mac_sat;

    logic                      m_valid_reg;
    logic signed [FIELD_W-1:0] result_reg;
    logic                      sat_reg, bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_W'(32);
            size_y_reg <= SIZE_W'(32);
            size_z_reg <= SIZE_W'(32);
            mode_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SIZE_X: size_x_reg <= cfg_wdata;
                CFG_SIZE_Y: size_y_reg <= cfg_wdata;
                CFG_SIZE_Z: size_z_reg <= cfg_wdata;
                CFG_MODE:   mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    spm_seq #(
        .DIM_X_MAX(DIM_X_MAX),
        .DIM_Y_MAX(DIM_Y_MAX),
        .DIM_Z_MAX(DIM_Z_MAX),
        .AW(AW)
    ) u_seq (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_pos_i(s_pos_i),
        .s_pos_j(s_pos_j),
        .s_pos_k(s_pos_k),
        .size_x(size_x_reg),
        .size_y(size_y_reg),
        .size_z(size_z_reg),
        .mode(mode_reg),
        .out_free(out_free),
        .ld_en(ld_en),
        .ld_addr(ld_addr),
        .clear(clear),
        .issue_ctl(issue_ctl),
        .coef_addr(coef_addr),
        .vec_addr(vec_addr),
        .out_ctl(out_ctl)
    );

    spm_ram #(.AW(AW), .DW(VW)) u_center (
        .aclk(aclk), .we(ld_en), .waddr(ld_addr), .wdata(VW'(s_coef_center)),
        .raddr(coef_addr), .rdata(center_q)
    );

    spm_ram #(.AW(AW), .DW(VW)) u_right (
        .aclk(aclk), .we(ld_en), .waddr(ld_addr), .wdata(VW'(s_coef_right)),
        .raddr(coef_addr), .rdata(right_q)
    );

    spm_ram #(.AW(AW), .DW(VW)) u_up (
        .aclk(aclk), .we(ld_en), .waddr(ld_addr), .wdata(VW'(s_coef_up)),
        .raddr(coef_addr), .rdata(up_q)
    );

    spm_ram #(.AW(AW), .DW(VW)) u_front (
        .aclk(aclk), .we(ld_en), .waddr(ld_addr), .wdata(VW'(s_coef_front)),
        .raddr(coef_addr), .rdata(front_q)
    );

    spm_ram #(.AW(AW), .DW(VW)) u_rhs (
        .aclk(aclk), .we(ld_en), .waddr(ld_addr), .wdata(VW'(s_rhs_value)),
        .raddr(coef_addr), .rdata(rhs_q)
    );

    spm_ram #(.AW(AW), .DW(VW)) u_vec (
        .aclk(aclk), .we(ld_en), .waddr(ld_addr), .wdata(VW'(s_vec_value)),
        .raddr(vec_addr), .rdata(vec_q)
    );

    spm_mac #(.VW(VW)) u_mac (
        .aclk(aclk),
        .aresetn(aresetn),
        .clear(clear),
        .issue_ctl(issue_ctl),
        .center_q(center_q),
        .right_q(right_q),
        .up_q(up_q),
        .front_q(front_q),
        .rhs_q(rhs_q),
        .vec_q(vec_q),
        .result(mac_result),
        .saturated(mac_sat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ctl.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_ctl.load) begin
            result_reg <= out_ctl.bad ? '0 : mac_result;
            sat_reg    <= out_ctl.bad ? 1'b0 : mac_sat;
            bad_reg    <= out_ctl.bad;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = result_reg;
    assign m_saturated    = sat_reg;
    assign m_bad_index    = bad_reg;

    `ASSERT_NEXT(a_busy_after_compute, s_valid && s_ready && s_operation == OP_COMPUTE, !s_ready)
    `ASSERT_NEXT(a_load_stays_idle, s_valid && s_ready && s_operation == OP_LOAD, s_ready)
    `ASSERT_SAME(a_bad_is_zero, m_valid && m_bad_index, m_result_value == '0 && !m_saturated)

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import spm_pkg::*;

    class stencil_scoreboard;
        typedef struct {
            logic [31:0] value;
            logic        sat;
            logic        bad;
        } stencil_result_t;

        localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF;
        localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;

        logic signed [31:0] center_mem[32768];
        logic signed [31:0] right_mem[32768];
        logic signed [31:0] up_mem[32768];
        logic signed [31:0] front_mem[32768];
        logic signed [31:0] vector_mem[32768];
        logic signed [31:0] rhs_mem[32768];
        int unsigned size_x = 32, size_y = 32, size_z = 32, mode = 0;
        stencil_result_t pending_results[$];
        int errors = 0, n_loads = 0, n_computes = 0, n_sat = 0, n_bad = 0;

        function void set_reg(cfg_index_t idx, logic [SIZE_W-1:0] data);
            case (idx)
                CFG_SIZE_X: size_x = 32'(data);
                CFG_SIZE_Y: size_y = 32'(data);
                CFG_SIZE_Z: size_z = 32'(data);
                CFG_MODE:   mode = 32'(data[0]);
                default: ;
            endcase
        endfunction

        function int unsigned at(int unsigned i, int unsigned j, int unsigned k);
            return (k * 32 + j) * 32 + i;
        endfunction

        function int unsigned used(int unsigned s);
            return (s > 32) ? 32 : s;
        endfunction

        function logic signed [127:0] prod(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [127:0] wa, wb;
            wa = a;
            wb = b;
            return wa * wb;
        endfunction

        function void note_word(logic op, int unsigned i, int unsigned j, int unsigned k,
                                logic signed [31:0] c, logic signed [31:0] r,
                                logic signed [31:0] u, logic signed [31:0] f,
                                logic signed [31:0] v, logic signed [31:0] h);
            int unsigned sx, sy, sz, p;
            logic signed [127:0] acc, rw, shifted;
            stencil_result_t res;
            sx = used(size_x);
            sy = used(size_y);
            sz = used(size_z);
            p = at(i, j, k);
            if (op == OP_LOAD) begin
                center_mem[p] = c;
                right_mem[p] = r;
                up_mem[p] = u;
                front_mem[p] = f;
                vector_mem[p] = v;
                rhs_mem[p] = h;
                n_loads++;
                return;
            end
            n_computes++;
            res = '{value: 32'd0, sat: 1'b0, bad: 1'b0};
            if (i >= sx || j >= sy || k >= sz) begin
                res.bad = 1'b1;
                n_bad++;
                pending_results.push_back(res);
                return;
            end
            acc = prod(center_mem[p], vector_mem[p]);
            if (i > 0) acc += prod(right_mem[at(i-1, j, k)], vector_mem[at(i-1, j, k)]);
            if (i + 1 < sx) acc += prod(right_mem[p], vector_mem[at(i+1, j, k)]);
            if (j > 0) acc += prod(up_mem[at(i, j-1, k)], vector_mem[at(i, j-1, k)]);
            if (j + 1 < sy) acc += prod(up_mem[p], vector_mem[at(i, j+1, k)]);
            if (k > 0) acc += prod(front_mem[at(i, j, k-1)], vector_mem[at(i, j, k-1)]);
            if (k + 1 < sz) acc += prod(front_mem[p], vector_mem[at(i, j, k+1)]);
            if (mode != 0) begin
                rw = rhs_mem[p];
                acc = (rw <<< FRAC_BITS) - acc;
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > Q_MAX) begin
                res.value = 32'h7FFF_FFFF;
                res.sat = 1'b1;
            end else if (shifted < Q_MIN) begin
                res.value = 32'h8000_0000;
                res.sat = 1'b1;
            end else begin
                res.value = shifted[31:0];
            end
            if (res.sat) n_sat++;
            pending_results.push_back(res);
        endfunction

        function void check_word(logic [31:0] value, logic sat, logic bad);
            stencil_result_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word value=%h sat=%b bad=%b",
                         $time, value, sat, bad);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (value !== exp_res.value) begin
                $display("%0t: result_value expected %h actual %h",
                         $time, exp_res.value, value);
                errors++;
            end
            if (sat !== exp_res.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, exp_res.sat, sat);
                errors++;
            end
            if (bad !== exp_res.bad) begin
                $display("%0t: bad_index expected %b actual %b", $time, exp_res.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = OP_LOAD;
    logic [POS_W-1:0] s_pos_i = '0, s_pos_j = '0, s_pos_k = '0;
    logic signed [FIELD_W-1:0] s_coef_center = '0, s_coef_right = '0, s_coef_up = '0;
    logic signed [FIELD_W-1:0] s_coef_front = '0, s_vec_value = '0, s_rhs_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [FIELD_W-1:0] m_result_value;
    logic m_saturated, m_bad_index;

    stencil_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned words_sent = 0;
    bit hold_go = 1'b0;
    int unsigned cur_x, cur_y, cur_z;

    seven_point_stencil_matvec u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_pos_i(s_pos_i), .s_pos_j(s_pos_j), .s_pos_k(s_pos_k),
        .s_coef_center(s_coef_center), .s_coef_right(s_coef_right),
        .s_coef_up(s_coef_up), .s_coef_front(s_coef_front),
        .s_vec_value(s_vec_value), .s_rhs_value(s_rhs_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_saturated(m_saturated), .m_bad_index(m_bad_index)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 1000000) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_result_value, m_saturated, m_bad_index);
    end

    // The receiver cycles through free-running, light and heavy stall patterns,
    // and holds off completely for a long stretch when asked.
    initial begin
        int unsigned pattern_kind;
        forever begin
            pattern_kind = $urandom_range(0, 2);
            repeat (64) begin
                @(negedge aclk);
                if (hold_go) begin
                    hold_go = 1'b0;
                    m_ready = 1'b0;
                    repeat (300) @(negedge aclk);
                end
                case (pattern_kind)
                    0: m_ready = 1'b1;
                    1: m_ready = ($urandom_range(0, 3) != 0);
                    default: m_ready = ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
        endcase
    endfunction

    task automatic send_word(logic op, int unsigned i, int unsigned j, int unsigned k);
        s_operation = op;
        s_pos_i = POS_W'(i);
        s_pos_j = POS_W'(j);
        s_pos_k = POS_W'(k);
        s_coef_center = pick_value();
        s_coef_right = pick_value();
        s_coef_up = pick_value();
        s_coef_front = pick_value();
        s_vec_value = pick_value();
        s_rhs_value = pick_value();
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(op, i, j, k, s_coef_center, s_coef_right, s_coef_up,
                     s_coef_front, s_vec_value, s_rhs_value);
        words_sent++;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [SIZE_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_grid(int unsigned sx, int unsigned sy, int unsigned sz, int unsigned md);
        drain_results();
        write_reg(CFG_SIZE_X, SIZE_W'(sx));
        write_reg(CFG_SIZE_Y, SIZE_W'(sy));
        write_reg(CFG_SIZE_Z, SIZE_W'(sz));
        write_reg(CFG_MODE, SIZE_W'(md));
        cur_x = (sx > 32) ? 32 : sx;
        cur_y = (sy > 32) ? 32 : sy;
        cur_z = (sz > 32) ? 32 : sz;
    endtask

    task automatic load_grid();
        for (int unsigned k = 0; k < cur_z; k++)
            for (int unsigned j = 0; j < cur_y; j++)
                for (int unsigned i = 0; i < cur_x; i++)
                    send_word(OP_LOAD, i, j, k);
    endtask

    task automatic random_words(int unsigned count);
        int unsigned roll;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50 && cur_x * cur_y * cur_z != 0)
                send_word(OP_COMPUTE, $urandom_range(0, cur_x - 1),
                          $urandom_range(0, cur_y - 1), $urandom_range(0, cur_z - 1));
            else if (roll < 65)
                send_word(OP_COMPUTE, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31));
            else if (roll < 80 && cur_x * cur_y * cur_z != 0)
                send_word(OP_LOAD, $urandom_range(0, cur_x - 1),
                          $urandom_range(0, cur_y - 1), $urandom_range(0, cur_z - 1));
            else
                send_word(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31));
        end
    endtask

    initial begin
        int unsigned phase;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Small grid with corner and off-grid computes in both modes, then an empty grid.
        set_grid(2, 2, 2, 0);
        load_grid();
        send_word(OP_COMPUTE, 0, 0, 0);
        send_word(OP_COMPUTE, 1, 1, 1);
        send_word(OP_COMPUTE, 1, 0, 1);
        send_word(OP_COMPUTE, 31, 31, 31);
        send_word(OP_COMPUTE, 2, 0, 0);
        set_grid(2, 2, 2, 1);
        send_word(OP_COMPUTE, 0, 1, 0);
        send_word(OP_COMPUTE, 1, 1, 1);
        set_grid(0, 0, 0, 0);
        send_word(OP_COMPUTE, 0, 0, 0);
        send_word(OP_LOAD, 31, 31, 31);

        phase = 0;
        while (words_sent < 950) begin
            case (phase % 8)
                0: set_grid(32, 1, 1, $urandom_range(0, 1));
                1: set_grid(1, 32, 1, $urandom_range(0, 1));
                2: set_grid(1, 1, 32, $urandom_range(0, 1));
                3: set_grid(63, 1, 2, $urandom_range(0, 1));
                4: set_grid(1, 1, 1, $urandom_range(0, 1));
                5: set_grid($urandom_range(0, 1) ? 0 : 63, 3, 3, $urandom_range(0, 1));
                default: set_grid($urandom_range(1, 5), $urandom_range(1, 5),
                                  $urandom_range(1, 4), $urandom_range(0, 1));
            endcase
            load_grid();
            if (phase == 2) hold_go = 1'b1;
            random_words(60);
            phase++;
        end

        drain_results();
        $display("Covered %0d loads and %0d computes (%0d saturated, %0d off-grid).",
                 sb.n_loads, sb.n_computes, sb.n_sat, sb.n_bad);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
